// ----- rtl/core/sfb_pkg.sv -----
// ----------------------------------------------------------------------------
// sfb_pkg
// Types, constants and the CRC-32 byte update shared by the frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int LEN_W       = 16;
    localparam int SID_W       = 64;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int MAXP_W      = 11;
    localparam int IDX_W       = 5;

    localparam int MAX_PAYLOAD_BYTES_DEF = 1024;
    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 11'd1024;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Header byte positions
    localparam logic [IDX_W-1:0] HDR_MAGIC0  = 5'd0;
    localparam logic [IDX_W-1:0] HDR_MAGIC1  = 5'd1;
    localparam logic [IDX_W-1:0] HDR_VERSION = 5'd2;
    localparam logic [IDX_W-1:0] HDR_TYPE    = 5'd3;
    localparam logic [IDX_W-1:0] HDR_SID     = 5'd4;
    localparam logic [IDX_W-1:0] HDR_SID_END = 5'd11;
    localparam logic [IDX_W-1:0] HDR_SEQ     = 5'd12;
    localparam logic [IDX_W-1:0] HDR_SEQ_END = 5'd15;
    localparam logic [IDX_W-1:0] HDR_LEN_LO  = 5'd16;
    localparam logic [IDX_W-1:0] HDR_LEN_HI  = 5'd17;
    localparam logic [IDX_W-1:0] CRC_LAST    = 5'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC_FIRST    = 2'd0,
        CFG_MAGIC_SECOND   = 2'd1,
        CFG_FORMAT_VERSION = 2'd2,
        CFG_MAX_PAYLOAD    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_HEAD = 1'b0,
        ST_TAIL = 1'b1
    } t_state;

    typedef struct packed {
        logic [7:0]        magic_first;
        logic [7:0]        magic_second;
        logic [7:0]        format_version;
        logic [MAXP_W-1:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic             action;
        logic [7:0]       frame_type;
        logic [SID_W-1:0] source_id;
        logic [LEN_W-1:0] body_len;
        logic [7:0]       payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             frame_end;
        logic             rejected;
        logic [CNT_W-1:0] oversize_total;
        logic             run_last;
    } t_out_item;

    function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/sfb_stream_if.sv -----
// ----------------------------------------------------------------------------
// sfb_stream_if
// Valid/ready stream channel carrying one payload of type T_PAYLOAD.
// ----------------------------------------------------------------------------
interface sfb_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/sfb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sfb_cfg_regs
// Header and size-limit configuration registers, write-only port.
// ----------------------------------------------------------------------------
module sfb_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sfb_pkg::t_cfg                  o_cfg
);
    import sfb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_first    <= '0;
            r_cfg.magic_second   <= '0;
            r_cfg.format_version <= '0;
            r_cfg.max_payload    <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAGIC_FIRST:    r_cfg.magic_first    <= i_cfg_data[7:0];
                CFG_MAGIC_SECOND:   r_cfg.magic_second   <= i_cfg_data[7:0];
                CFG_FORMAT_VERSION: r_cfg.format_version <= i_cfg_data[7:0];
                CFG_MAX_PAYLOAD:    r_cfg.max_payload    <= i_cfg_data[MAXP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/sfb_framer.sv -----
// ----------------------------------------------------------------------------
// sfb_framer
// Request register, byte sequencer with running CRC-32, and output register.
// ----------------------------------------------------------------------------
module sfb_framer #(
    parameter int MAX_PAYLOAD_BYTES = sfb_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfb_pkg::t_cfg i_cfg,
    sfb_stream_if.sink    i_in,
    sfb_stream_if.source  o_out
);
    import sfb_pkg::*;

    localparam logic [LEN_W-1:0] LIMIT_PARAM = LEN_W'(MAX_PAYLOAD_BYTES);

    t_in_item         r_cur;
    logic             r_cur_valid;
    t_state           r_state,     n_state;
    logic [IDX_W-1:0] r_idx,       n_idx;
    logic [CNT_W-1:0] r_seq,       n_seq;
    logic [31:0]      r_crc,       n_crc;
    logic [LEN_W-1:0] r_remaining, n_remaining;
    logic             r_open,      n_open;
    logic [CNT_W-1:0] r_oversize,  n_oversize;
    t_out_item        r_out;
    logic             r_out_valid;

    t_out_item        res;
    logic             emit;
    logic             item_done;
    logic             out_load;
    logic             step;
    logic             done;
    logic             in_ready;
    logic             cur_start;
    logic [LEN_W-1:0] cfg_limit;
    logic [LEN_W-1:0] limit;
    logic             oversize;
    logic [LEN_W-1:0] rem_after;
    logic [7:0]       hdr_byte;
    logic [2:0]       sid_sel;
    logic [1:0]       seq_sel;
    logic [1:0]       crc_sel;
    logic [31:0]      crc_final;

    assign cur_start = (r_cur.action == ACT_START);
    assign cfg_limit = LEN_W'(i_cfg.max_payload);
    assign limit     = (LIMIT_PARAM < cfg_limit) ? LIMIT_PARAM : cfg_limit;
    assign oversize  = (r_cur.body_len > limit);
    assign rem_after = (r_remaining != '0) ? (r_remaining - 1'b1) : '0;
    assign sid_sel   = 3'(r_idx - HDR_SID);
    assign seq_sel   = 2'(r_idx - HDR_SEQ);
    assign crc_sel   = r_idx[1:0];
    assign crc_final = ~r_crc;

    always_comb begin
        case (r_idx) inside
            HDR_MAGIC0:              hdr_byte = i_cfg.magic_first;
            HDR_MAGIC1:              hdr_byte = i_cfg.magic_second;
            HDR_VERSION:             hdr_byte = i_cfg.format_version;
            HDR_TYPE:                hdr_byte = r_cur.frame_type;
            [HDR_SID:HDR_SID_END]:   hdr_byte = r_cur.source_id[sid_sel*8 +: 8];
            [HDR_SEQ:HDR_SEQ_END]:   hdr_byte = r_seq[seq_sel*8 +: 8];
            HDR_LEN_LO:              hdr_byte = r_cur.body_len[7:0];
            HDR_LEN_HI:              hdr_byte = r_cur.body_len[15:8];
            default:                 hdr_byte = '0;
        endcase
    end

    // Result and state updates for the current position
    always_comb begin
        emit        = 1'b0;
        item_done   = 1'b0;
        res         = '0;
        n_seq       = r_seq;
        n_crc       = r_crc;
        n_remaining = r_remaining;
        n_open      = r_open;
        n_oversize  = r_oversize;
        unique case (r_state)
            ST_HEAD: begin
                if (cur_start) begin
                    emit = 1'b1;
                    if (oversize) begin
                        n_oversize   = r_oversize + 1'b1;
                        res.rejected = 1'b1;
                        res.run_last = 1'b1;
                        item_done    = 1'b1;
                    end else begin
                        res.out_byte   = hdr_byte;
                        res.byte_valid = 1'b1;
                        n_crc = crc32_byte((r_idx == HDR_MAGIC0) ? CRC_INIT : r_crc, hdr_byte);
                        if (r_idx == HDR_MAGIC0) begin
                            n_seq       = r_seq + 1'b1;
                            n_open      = 1'b1;
                            n_remaining = r_cur.body_len;
                        end
                        if (r_idx == HDR_LEN_HI && r_cur.body_len != '0) begin
                            res.run_last = 1'b1;
                            item_done    = 1'b1;
                        end
                    end
                end else if (r_open) begin
                    emit           = 1'b1;
                    res.out_byte   = r_cur.payload_byte;
                    res.byte_valid = 1'b1;
                    n_crc          = crc32_byte(r_crc, r_cur.payload_byte);
                    n_remaining    = rem_after;
                    if (rem_after != '0) begin
                        res.run_last = 1'b1;
                        item_done    = 1'b1;
                    end
                end else begin
                    // stray payload byte: consumed silently
                    item_done = 1'b1;
                end
            end
            ST_TAIL: begin
                emit           = 1'b1;
                res.out_byte   = crc_final[crc_sel*8 +: 8];
                res.byte_valid = 1'b1;
                if (r_idx == CRC_LAST) begin
                    res.frame_end = 1'b1;
                    res.run_last  = 1'b1;
                    item_done     = 1'b1;
                    n_open        = 1'b0;
                end
            end
            default: ;
        endcase
        res.oversize_total = n_oversize;
    end

    assign out_load = !r_out_valid || o_out.ready;
    assign step     = r_cur_valid && (!emit || out_load);
    assign done     = step && item_done;
    assign in_ready = !r_cur_valid || done;

    // Position sequencing
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (step) begin
            if (item_done) begin
                n_state = ST_HEAD;
                n_idx   = '0;
            end else if (r_state == ST_HEAD && (!cur_start || r_idx == HDR_LEN_HI)) begin
                n_state = ST_TAIL;
                n_idx   = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_state     <= ST_HEAD;
            r_idx       <= '0;
            r_seq       <= '0;
            r_crc       <= CRC_INIT;
            r_remaining <= '0;
            r_open      <= 1'b0;
            r_oversize  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready && i_in.valid) begin
                r_cur_valid <= 1'b1;
            end else if (done) begin
                r_cur_valid <= 1'b0;
            end
            r_state <= n_state;
            r_idx   <= n_idx;
            if (step) begin
                r_seq       <= n_seq;
                r_crc       <= n_crc;
                r_remaining <= n_remaining;
                r_open      <= n_open;
                r_oversize  <= n_oversize;
            end
            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_cur <= i_in.payload;
        end
        if (step && emit) begin
            r_out <= res;
        end
    end

    assign i_in.ready    = in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// ----- rtl/core/stream_frame_builder_crc32_top.sv -----
// ----------------------------------------------------------------------------
// stream_frame_builder_crc32_top
// Builds framed byte streams with an 18-byte header and CRC-32 trailer.
//
// i_in takes requests: a start request (action 0) opens a frame, a payload
// request (action 1) carries one byte. o_out gives at most one frame byte per result,
// with frame_end on the last CRC byte and run_last on the last result of a
// request. i_cfg_* writes the magic, version and size-limit registers.
// A request sits in one input register; results leave through an output
// register. The byte sequencer emits one result per cycle while o_out is not
// stalled, so back-to-back payload requests stream at one byte per cycle. A
// start gives the header bytes (and the CRC bytes for a zero-length frame),
// a payload byte that closes a frame gives its byte and the CRC bytes, an
// oversize start gives one rejected result, and a byte outside a frame gives
// none. Reset clears the sequence number, oversize count and open frame, and
// sets max_payload to 1024. When o_out stalls, the output register holds its
// result and i_in takes no request while its current request has one to give.
// ----------------------------------------------------------------------------
module stream_frame_builder_crc32_top #(
    parameter int MAX_PAYLOAD_BYTES = sfb_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sfb_stream_if.sink                     i_in,
    sfb_stream_if.source                   o_out
);
    import sfb_pkg::*;

    t_cfg cfg;

    sfb_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sfb_framer #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ----- bench/tb_stream_frame_builder_crc32_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_frame_builder_crc32_top
// Drives start and payload requests through the frame builder, predicts every
// header, payload and CRC byte from a local copy of the framing rules and
// registers, and checks each result in order under random source and sink
// stalls, across several register settings.
// ----------------------------------------------------------------------------
module tb_stream_frame_builder_crc32_top;
    import sfb_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 17;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sfb_stream_if #(.T_PAYLOAD(t_in_item))  req_if ();
    sfb_stream_if #(.T_PAYLOAD(t_out_item)) res_if ();

    stream_frame_builder_crc32_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (res_if)
    );

    t_in_item  pending_reqs [$];
    t_out_item expected_bytes [$];
    t_out_item run_q [$];
    int        mismatch_cnt;
    int        cycle_cnt;
    bit        quiet;

    // framer model state and register copy
    logic [7:0]        m_magic0;
    logic [7:0]        m_magic1;
    logic [7:0]        m_version;
    logic [MAXP_W-1:0] m_max_payload;
    logic [31:0]       m_seq;
    logic [31:0]       m_crc;
    logic [LEN_W-1:0]  m_left;
    logic              m_open;
    logic [CNT_W-1:0]  m_oversize;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc_update(logic [31:0] acc, logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) c = (c >> 1) ^ CRC_POLY;
            else             c = c >> 1;
        end
        return c;
    endfunction

    function automatic int eff_limit();
        return (m_max_payload > MAX_PAYLOAD_BYTES_DEF) ? MAX_PAYLOAD_BYTES_DEF
                                                        : int'(m_max_payload);
    endfunction

    function automatic t_out_item mk_result(logic [7:0] b, logic v, logic fe, logic rj);
        t_out_item r;
        r                = '0;
        r.out_byte       = b;
        r.byte_valid     = v;
        r.frame_end      = fe;
        r.rejected       = rj;
        r.oversize_total = m_oversize;
        return r;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        m_crc = crc_update(m_crc, b);
        run_q.push_back(mk_result(b, 1'b1, 1'b0, 1'b0));
    endfunction

    function automatic void add_fcs();
        logic [31:0] fcs;
        fcs = ~m_crc;
        for (int i = 0; i < 4; i++) begin
            run_q.push_back(mk_result(fcs[8*i +: 8], 1'b1, i == 3, 1'b0));
        end
        m_open = 1'b0;
    endfunction

    function automatic void predict_frame_bytes(t_in_item req);
        run_q.delete();
        if (req.action == ACT_START) begin
            if (int'(req.body_len) > eff_limit()) begin
                m_oversize = m_oversize + 1;
                run_q.push_back(mk_result(8'h00, 1'b0, 1'b0, 1'b1));
            end else begin
                m_crc  = CRC_INIT;
                m_seq  = m_seq + 1;
                m_open = 1'b1;
                m_left = req.body_len;
                add_byte(m_magic0);
                add_byte(m_magic1);
                add_byte(m_version);
                add_byte(req.frame_type);
                for (int i = 0; i < 8; i++) add_byte(req.source_id[8*i +: 8]);
                for (int i = 0; i < 4; i++) add_byte(m_seq[8*i +: 8]);
                add_byte(req.body_len[7:0]);
                add_byte(req.body_len[15:8]);
                if (req.body_len == 0) add_fcs();
            end
        end else if (m_open) begin
            add_byte(req.payload_byte);
            if (m_left > 0) m_left = m_left - 1'b1;
            if (m_left == 0) add_fcs();
        end
        if (run_q.size() > 0) run_q[run_q.size()-1].run_last = 1'b1;
        foreach (run_q[i]) expected_bytes.push_back(run_q[i]);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_cnt++;
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_bytes.size() == 0) begin
            report_mismatch("result with nothing pending", 64'(got), 64'(0));
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch("out_byte", 64'(got.out_byte), 64'(want.out_byte));
            if (got.byte_valid !== want.byte_valid)
                report_mismatch("byte_valid", 64'(got.byte_valid), 64'(want.byte_valid));
            if (got.frame_end !== want.frame_end)
                report_mismatch("frame_end", 64'(got.frame_end), 64'(want.frame_end));
            if (got.rejected !== want.rejected)
                report_mismatch("rejected", 64'(got.rejected), 64'(want.rejected));
            if (got.oversize_total !== want.oversize_total)
                report_mismatch("oversize_total", 64'(got.oversize_total),
                                64'(want.oversize_total));
            if (got.run_last !== want.run_last)
                report_mismatch("run_last", 64'(got.run_last), 64'(want.run_last));
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) predict_frame_bytes(req_if.payload);
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    req_if.valid   <= 1'b1;
                    req_if.payload <= pending_reqs.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_result(res_if.payload);
            res_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_in_item mk_start(logic [7:0] ft, logic [63:0] sid, logic [15:0] len);
        t_in_item r;
        r.action       = ACT_START;
        r.frame_type   = ft;
        r.source_id    = sid;
        r.body_len     = len;
        r.payload_byte = 8'($urandom);
        return r;
    endfunction

    function automatic t_in_item mk_byte(logic [7:0] b);
        t_in_item r;
        r.action       = ACT_PAYLOAD;
        r.frame_type   = 8'($urandom);
        r.source_id    = {$urandom, $urandom};
        r.body_len     = 16'($urandom);
        r.payload_byte = b;
        return r;
    endfunction

    function automatic t_in_item rand_start(int len);
        return mk_start(8'($urandom), {$urandom, $urandom}, 16'(len));
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_bytes.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_MAGIC_FIRST:    m_magic0      = val[7:0];
            CFG_MAGIC_SECOND:   m_magic1      = val[7:0];
            CFG_FORMAT_VERSION: m_version     = val[7:0];
            CFG_MAX_PAYLOAD:    m_max_payload = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [7:0] m0, logic [7:0] m1, logic [7:0] ver,
                             logic [CFG_DATA_W-1:0] maxp);
        write_reg(CFG_MAGIC_FIRST, CFG_DATA_W'(m0));
        write_reg(CFG_MAGIC_SECOND, CFG_DATA_W'(m1));
        write_reg(CFG_FORMAT_VERSION, CFG_DATA_W'(ver));
        write_reg(CFG_MAX_PAYLOAD, maxp);
    endtask

    task automatic random_phase(int n_items);
        int made;
        int pick;
        int lim;
        int len;
        int cut;
        bit gen_open;
        made     = 0;
        gen_open = 1'b0;
        lim      = eff_limit();
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70 || (pick < 80 && lim == 0)) begin
                if ($urandom_range(0, 9) == 0) len = $urandom_range(0, (lim < 64) ? lim : 64);
                else                           len = $urandom_range(0, (lim < 12) ? lim : 12);
                pending_reqs.push_back(rand_start(len));
                repeat (len) pending_reqs.push_back(mk_byte(8'($urandom)));
                made     += len + 1;
                gen_open = 1'b0;
            end else if (pick < 80) begin
                len = $urandom_range(1, (lim < 30) ? lim : 30);
                cut = $urandom_range(0, len - 1);
                pending_reqs.push_back(rand_start(len));
                repeat (cut) pending_reqs.push_back(mk_byte(8'($urandom)));
                made     += cut + 1;
                gen_open = 1'b1;
            end else if (pick < 90) begin
                if ($urandom_range(0, 1) == 0) len = $urandom_range(lim + 1, lim + 4);
                else                           len = $urandom_range(lim + 1, 65535);
                pending_reqs.push_back(rand_start(len));
                made++;
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    pending_reqs.push_back(mk_byte(8'($urandom)));
                    if (gen_open) made++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        res_if.ready   = 1'b0;
        quiet          = 1'b0;
        mismatch_cnt   = 0;
        cycle_cnt      = 0;
        m_magic0       = 8'h00;
        m_magic1       = 8'h00;
        m_version      = 8'h00;
        m_max_payload  = MAX_PAYLOAD_RST;
        m_seq          = '0;
        m_crc          = CRC_INIT;
        m_left         = '0;
        m_open         = 1'b0;
        m_oversize     = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // zero-length frame, stray byte, full-size frame abandoned after
        // oversize starts that must leave it open
        @(negedge i_clk);
        pending_reqs.push_back(mk_start(8'h00, 64'h0, 16'd0));
        pending_reqs.push_back(mk_byte(8'hFF));
        pending_reqs.push_back(mk_start(8'hFF, '1, 16'd1024));
        pending_reqs.push_back(mk_byte(8'h00));
        pending_reqs.push_back(rand_start(1025));
        pending_reqs.push_back(mk_byte(8'hFF));
        pending_reqs.push_back(rand_start(65535));
        pending_reqs.push_back(mk_start(8'h5A, {$urandom, $urandom}, 16'd2));
        pending_reqs.push_back(mk_byte(8'hAA));
        pending_reqs.push_back(mk_byte(8'h55));
        settle();

        write_all(8'hFF, 8'hFF, 8'hFF, '0);
        @(negedge i_clk);
        pending_reqs.push_back(rand_start(0));
        pending_reqs.push_back(rand_start(1));
        settle();

        write_reg(CFG_MAX_PAYLOAD, '1);
        @(negedge i_clk);
        pending_reqs.push_back(rand_start(1025));
        pending_reqs.push_back(rand_start(1));
        pending_reqs.push_back(mk_byte(8'h81));
        settle();

        write_all(8'h5A, 8'hC3, 8'h01, 11'd3);
        @(negedge i_clk);
        pending_reqs.push_back(rand_start(3));
        repeat (3) pending_reqs.push_back(mk_byte(8'($urandom)));
        pending_reqs.push_back(rand_start(4));
        settle();

        write_all(8'($urandom), 8'($urandom), 8'($urandom), 11'd2047);
        random_phase(90);
        settle();

        write_all(8'hFF, 8'h00, 8'h7F, 11'($urandom_range(1, 40)));
        quiet = 1'b1;
        random_phase(90);
        settle();
        quiet = 1'b0;

        write_all(8'($urandom), 8'($urandom), 8'($urandom), '0);
        random_phase(40);
        settle();

        write_all(8'($urandom), 8'($urandom), 8'($urandom), 11'($urandom_range(0, 2047)));
        random_phase(50);
        drain();
        random_phase(50);
        settle();

        write_all(8'($urandom), 8'($urandom), 8'($urandom), MAX_PAYLOAD_RST);
        random_phase(100);
        settle();

        if (expected_bytes.size() > 0)
            report_mismatch("results never received", 64'(expected_bytes.size()), 64'(0));
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sfb_pkg.sv
rtl/core/sfb_stream_if.sv
rtl/core/sfb_cfg_regs.sv
rtl/core/sfb_framer.sv
rtl/core/stream_frame_builder_crc32_top.sv
bench/tb_stream_frame_builder_crc32_top.sv
